// File: design/olrbk_pkg.sv
// ----------------------------------------------------------------------------
// olrbk_pkg
// Shared types and constants of the ordered record list.
// ----------------------------------------------------------------------------
`default_nettype none

package olrbk_pkg;

   // Default number of records the list holds
   localparam int DefCapacity = 64;

   // Width of one record word and of the reported count
   localparam int WordW = 64;
   localparam int FillW = 7;

   // Operation codes
   localparam logic CmdAppend = 1'b0;
   localparam logic CmdRemove = 1'b1;

   // One stored record
   typedef struct packed {
      logic [WordW-1:0] name;
      logic [WordW-1:0] color;
      logic [WordW-1:0] hardness;
      logic [WordW-1:0] reactivity;
   } record_type;

   // Request transaction
   typedef struct packed {
      logic             cmd;
      logic [WordW-1:0] key_name;
      logic [WordW-1:0] color_word;
      logic [WordW-1:0] hardness_word;
      logic [WordW-1:0] reactivity_word;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic             ok;
      logic [WordW-1:0] out_name;
      logic [WordW-1:0] out_color;
      logic [WordW-1:0] out_hardness;
      logic [WordW-1:0] out_reactivity;
      logic [FillW-1:0] fill_after;
      logic             is_empty;
   } rsp_type;

endpackage

`default_nettype wire

// File: design/olrbk_mem.sv
// ----------------------------------------------------------------------------
// olrbk_mem
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module olrbk_mem
   import olrbk_pkg::*;
#(
   parameter int Capacity = DefCapacity,
   parameter int AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire record_type       wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output record_type            rd_data
);

   record_type store_ff [Capacity];
   record_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/olrbk_ctrl.sv
// ----------------------------------------------------------------------------
// olrbk_ctrl
// Sequencer: append, head-first key search and compaction shift over the store.
// ----------------------------------------------------------------------------
`default_nettype none

module olrbk_ctrl
   import olrbk_pkg::*;
#(
   parameter int Capacity = DefCapacity,
   parameter int AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1,
   parameter int CntW     = $clog2(Capacity + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request side
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   // result towards the output register
   output logic                  res_valid,
   input  wire logic             res_ready,
   output rsp_type               res_data,
   // store access
   output logic                  wr_en,
   output logic [AddrW-1:0]      wr_addr,
   output record_type            wr_data,
   output logic [AddrW-1:0]      rd_addr,
   input  wire record_type       rd_data
);

   typedef enum logic [1:0] {
      StIdle,
      StSearch,
      StShift,
      StDone
   } state_type;

   state_type         state_ff, state_in;
   logic [CntW-1:0]   fill_ff, fill_in;
   logic [CntW-1:0]   idx_ff, idx_in;
   logic [WordW-1:0]  key_ff, key_in;
   rsp_type           res_ff, res_in;

   logic [CntW-1:0]   idx_p1;
   logic [CntW-1:0]   idx_p2;

   assign idx_p1 = idx_ff + CntW'(1);
   assign idx_p2 = idx_ff + CntW'(2);

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = fill_ff[AddrW-1:0];
      wr_data  = rd_data;
      rd_addr  = '0;

      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               key_in   = req_data.key_name;
               res_in   = '0;
               idx_in   = '0;
               state_in = StDone;
               if (req_data.cmd == CmdAppend) begin
                  if (fill_ff < CntW'(Capacity)) begin
                     wr_en              = 1'b1;
                     wr_data.name       = req_data.key_name;
                     wr_data.color      = req_data.color_word;
                     wr_data.hardness   = req_data.hardness_word;
                     wr_data.reactivity = req_data.reactivity_word;
                     fill_in            = fill_ff + CntW'(1);
                     res_in.ok          = 1'b1;
                  end
               end else if (fill_ff != '0) begin
                  // start the search at the head
                  rd_addr  = '0;
                  state_in = StSearch;
               end
            end
         end

         StSearch: begin
            // rd_data holds entry idx_ff; fetch the next one meanwhile
            rd_addr = idx_p1[AddrW-1:0];
            if (rd_data.name == key_ff) begin
               res_in.ok             = 1'b1;
               res_in.out_name       = rd_data.name;
               res_in.out_color      = rd_data.color;
               res_in.out_hardness   = rd_data.hardness;
               res_in.out_reactivity = rd_data.reactivity;
               fill_in               = fill_ff - CntW'(1);
               state_in              = StShift;
            end else if (idx_p1 < fill_ff) begin
               idx_in = idx_p1;
            end else begin
               state_in = StDone;
            end
         end

         StShift: begin
            // rd_data holds entry idx_ff + 1; move it up one place
            if (idx_ff < fill_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[AddrW-1:0];
               wr_data = rd_data;
               rd_addr = idx_p2[AddrW-1:0];
               idx_in  = idx_p1;
            end else begin
               state_in = StDone;
            end
         end

         StDone: begin
            if (res_ready) begin
               state_in = StIdle;
            end
         end

         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      idx_ff <= idx_in;
      key_ff <= key_in;
      res_ff <= res_in;
   end

   assign req_ready = (state_ff == StIdle);
   assign res_valid = (state_ff == StDone);

   // Count fields follow the final fill
   always_comb begin
      res_data            = res_ff;
      res_data.fill_after = FillW'(fill_ff);
      res_data.is_empty   = (fill_ff == '0);
   end

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CntW'(Capacity))
      else $error("fill count above capacity");

   a_search_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StSearch) |-> (idx_ff < fill_ff))
      else $error("search index beyond fill");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> ({1'b0, fill_ff} == {1'b0, $past(fill_ff)}
                  || {1'b0, fill_ff} == {1'b0, $past(fill_ff)} + 1'b1
                  || {1'b0, fill_ff} + 1'b1 == {1'b0, $past(fill_ff)}))
      else $error("fill count moved by more than one");

   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
      else $error("result dropped or changed while held");

endmodule

`default_nettype wire

// File: design/ordered_list_remove_by_key.sv
// ----------------------------------------------------------------------------
// ordered_list_remove_by_key
// Bounded ordered record list with append and remove-by-key.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command transaction: an append stores the record at
//   the tail, a remove finds the first record from the head whose name equals
//   key_name, returns it and closes the gap so the order is kept.
//   rsp_* returns exactly one transaction per request: success, the removed
//   record (zero otherwise), the count after the operation and an empty flag.
// Sequencing:
//   A remove searches from the head for the matching record, then shifts
//   each following record up one place to close the gap; search and shift
//   are both bound by the single read and single write port of the record
//   store. A miss searches the whole list and shifts nothing. The next
//   request is accepted once the current one has its result in the output
//   register.
// Reset clears the count and empties the output register; store contents
//   are not cleared and never used before they are written.
// A stalled rsp_ready holds the result; one further request may still be
//   processed, then req_ready stays low until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_remove_by_key
   import olrbk_pkg::*;
#(
   parameter int Capacity = DefCapacity
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int CntW  = $clog2(Capacity + 1);

   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   record_type       wr_data;
   logic [AddrW-1:0] rd_addr;
   record_type       rd_data;

   logic             res_valid;
   logic             res_ready;
   rsp_type          res_data;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   olrbk_mem #(
      .Capacity (Capacity),
      .AddrW    (AddrW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   olrbk_ctrl #(
      .Capacity (Capacity),
      .AddrW    (AddrW),
      .CntW     (CntW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // Output register: loads whenever it is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: tb/tb_ordered_list_remove_by_key.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_remove_by_key
// Self-checking testbench for the bounded ordered record list.
// A tracker class keeps its own copy of the list. It works out the reply to
// every accepted command and compares each returned transaction field by field.
// A short directed run covers the empty list, extreme words, duplicate names,
// and hits at the head, middle and tail. Random segments follow: fill, drain
// and mixed, with random idling on both sides. One long receiver hold backs
// the block up, and the tail of the run has no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ordered_list_remove_by_key
   import olrbk_pkg::*;
();

   localparam int ListDepth  = DefCapacity;
   localparam int NumRandom  = 680;
   localparam int CalmTail   = 100;
   localparam int HoldAt     = 200;
   localparam int LongHold   = 300;
   localparam int StallLimit = 4000;
   localparam int DrainWait  = 2 * ListDepth + 16;

   typedef enum int {ModeFill, ModeDrain, ModeMixed} mix_mode_type;

   // Own copy of the list; works out the reply due for each command
   class record_list_tracker;
      record_type held_records[$];
      rsp_type    due_replies[$];
      int         fault_count;

      function void note_command(req_type cmd_t);
         rsp_type    reply;
         record_type rec;
         int         hit;
         reply = '0;
         hit   = -1;
         if (cmd_t.cmd == CmdAppend) begin
            if (held_records.size() < ListDepth) begin
               rec.name       = cmd_t.key_name;
               rec.color      = cmd_t.color_word;
               rec.hardness   = cmd_t.hardness_word;
               rec.reactivity = cmd_t.reactivity_word;
               held_records.push_back(rec);
               reply.ok = 1'b1;
            end
         end else begin
            // first match from the head wins
            for (int i = 0; i < held_records.size(); i++) begin
               if (hit < 0 && held_records[i].name == cmd_t.key_name) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               reply.ok             = 1'b1;
               reply.out_name       = held_records[hit].name;
               reply.out_color      = held_records[hit].color;
               reply.out_hardness   = held_records[hit].hardness;
               reply.out_reactivity = held_records[hit].reactivity;
               held_records.delete(hit);
            end
         end
         reply.fill_after = FillW'(held_records.size());
         reply.is_empty   = (held_records.size() == 0);
         due_replies.push_back(reply);
      endfunction

      function void check_field(string field, logic [WordW-1:0] want,
                                logic [WordW-1:0] got);
         if (got !== want) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("mismatch %s: expected %h got %h", field, want, got);
            end
         end
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (due_replies.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("unexpected reply %h", got);
            end
         end else begin
            want = due_replies.pop_front();
            check_field("ok", WordW'(want.ok), WordW'(got.ok));
            check_field("out_name", want.out_name, got.out_name);
            check_field("out_color", want.out_color, got.out_color);
            check_field("out_hardness", want.out_hardness, got.out_hardness);
            check_field("out_reactivity", want.out_reactivity, got.out_reactivity);
            check_field("fill_after", WordW'(want.fill_after), WordW'(got.fill_after));
            check_field("is_empty", WordW'(want.is_empty), WordW'(got.is_empty));
         end
      endfunction

      function int failures();
         return fault_count + due_replies.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   record_list_tracker tracker;
   logic [WordW-1:0]   name_pool[8];
   bit                 calm          = 1'b0;
   bit                 long_hold_req = 1'b0;
   int                 idle_pct      = 0;
   int                 stall_pct     = 0;
   int                 hold_left     = 0;
   int                 quiet_cycles  = 0;

   ordered_list_remove_by_key #(
      .Capacity(ListDepth)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic logic [WordW-1:0] rand_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type make_item(logic cmd, logic [WordW-1:0] name,
                                         logic [WordW-1:0] color,
                                         logic [WordW-1:0] hard,
                                         logic [WordW-1:0] react);
      req_type item;
      item.cmd             = cmd;
      item.key_name        = name;
      item.color_word      = color;
      item.hardness_word   = hard;
      item.reactivity_word = react;
      return item;
   endfunction

   // Mostly keys of records still held, so removes hit at any position
   function automatic logic [WordW-1:0] pick_remove_key();
      if (tracker.held_records.size() != 0 && $urandom_range(0, 3) != 0) begin
         return tracker.held_records[$urandom_range(0, tracker.held_records.size() - 1)].name;
      end else if ($urandom_range(0, 1) == 0) begin
         return name_pool[$urandom_range(0, 7)];
      end
      return rand_word();
   endfunction

   // Offer one transaction and hold it until accepted
   task automatic send_item(input req_type item);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_command(item);
   endtask

   // Stimulus and end of run
   initial begin : stimulus
      req_type      item;
      mix_mode_type mode;
      int           seg_left;
      int           append_pct;
      tracker = new();
      name_pool[0] = '0;
      name_pool[1] = '1;
      for (int i = 2; i < 8; i++) name_pool[i] = {$urandom, $urandom};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, extreme words, duplicates, head/middle/tail hits
      send_item(make_item(CmdRemove, '0, '1, '1, '1));
      send_item(make_item(CmdRemove, '1, '0, '0, '0));
      send_item(make_item(CmdAppend, '0, '0, '0, '0));
      send_item(make_item(CmdAppend, '1, '1, '1, '1));
      send_item(make_item(CmdAppend, {16{4'h5}}, {16{4'hA}}, {16{4'h5}}, {16{4'hA}}));
      send_item(make_item(CmdAppend, {16{4'h5}}, {16{4'h3}}, {16{4'hC}}, {16{4'h9}}));
      send_item(make_item(CmdAppend, {16{4'hA}}, {16{4'h5}}, {16{4'hA}}, {16{4'h5}}));
      send_item(make_item(CmdRemove, {16{4'h5}}, '1, '1, '1));
      send_item(make_item(CmdRemove, 64'h0123_4567_89AB_CDEF, '0, '0, '0));
      send_item(make_item(CmdRemove, {16{4'hA}}, '0, '0, '0));
      send_item(make_item(CmdRemove, {16{4'h5}}, '0, '0, '0));
      send_item(make_item(CmdRemove, {16{4'h5}}, '0, '0, '0));
      send_item(make_item(CmdRemove, '1, '0, '0, '0));
      send_item(make_item(CmdRemove, '0, '0, '0, '0));
      send_item(make_item(CmdRemove, '0, '0, '0, '0));
      send_item(make_item(CmdAppend, 64'h1, 64'h8000_0000_0000_0000, 64'h1, '1));
      send_item(make_item(CmdRemove, 64'h8000_0000_0000_0000, '0, '0, '0));
      send_item(make_item(CmdRemove, 64'h1, '0, '0, '0));

      // random segments; the first one fills the list past full
      mode     = ModeFill;
      seg_left = 100;
      for (int n = 0; n < NumRandom; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(30, 90);
            mode     = mix_mode_type'($urandom_range(0, 2));
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 15;
               default: idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 15;
               default: stall_pct = 40;
            endcase
         end
         seg_left--;
         if (n == HoldAt) long_hold_req = 1'b1;
         if (n == NumRandom - CalmTail) calm = 1'b1;
         case (mode)
            ModeFill:  append_pct = 95;
            ModeDrain: append_pct = 15;
            default:   append_pct = 50;
         endcase
         if ($urandom_range(0, 99) < append_pct) begin
            item = make_item(CmdAppend,
                             ($urandom_range(0, 1) == 0) ? name_pool[$urandom_range(0, 7)]
                                                         : rand_word(),
                             rand_word(), rand_word(), rand_word());
         end else begin
            item = make_item(CmdRemove, pick_remove_key(), rand_word(), rand_word(),
                             rand_word());
         end
         send_item(item);
      end
      req_valid <= 1'b0;

      // let outstanding replies come back, then allow for a stray one
      while (tracker.due_replies.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (tracker.failures() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Receiver: random short holds and one long hold to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LongHold - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         hold_left = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Reply check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_reply(rsp_data);
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
